// ===== design/trapezoidal_profile_generator_defines.svh =====
// assertion macros for the trapezoidal profile generator
// used by the top level only; define ASSERT_OFF to drop all checks
`ifndef TRAPEZOIDAL_PROFILE_GENERATOR_DEFINES_SVH
`define TRAPEZOIDAL_PROFILE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define TPG_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define TPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TPG_ASSERT(lbl, cond, msg)
`define TPG_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== design/tpg_pkg.sv =====
// shared types, constants and saturation helpers of the profile generator
// no dependencies
package tpg_pkg;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // register reset values
    localparam logic [31:0] START_RESET = 32'h0000_0000;
    localparam logic [31:0] END_RESET   = 32'h0001_0000;
    localparam logic [31:0] ACC_RESET   = 32'h0001_0000;
    localparam logic [31:0] SPD_RESET   = 32'h0001_0000;
    localparam logic [16:0] RATE_RESET  = 17'd1000;

    // configuration register indexes
    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_END   = 3'd1;
    localparam logic [2:0] REG_ACC   = 3'd2;
    localparam logic [2:0] REG_SPD   = 3'd3;
    localparam logic [2:0] REG_RATE  = 3'd4;

    // request to the shared divide / square root unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } dsq_req_t;

    function automatic logic [31:0] sat32(input logic [63:0] x);
        return (|x[63:32]) ? SAT32 : x[31:0];
    endfunction

    function automatic logic [31:0] addsat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

// ===== design/tpg_divsqrt.sv =====
// shared iterative unit: 64/32 restoring divide or 64-bit
// integer square root, one result bit per cycle
// depends on tpg_pkg
module tpg_divsqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  tpg_pkg::dsq_req_t req,
    input  logic [63:0]      operand,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [63:0]      result
);

    logic        busy_reg, busy_next;
    logic        sqrt_reg, sqrt_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] dvs_reg, dvs_next;

    logic [35:0] sub_a, sub_b;
    logic [36:0] diff;
    logic        ge;
    logic        last_step;

    // one shared subtractor for both operations
    always_comb
    begin
        if (sqrt_reg)
        begin
            sub_a = {rem_reg[33:0], acc_reg[63:62]};
            sub_b = {2'b00, root_reg, 2'b01};
        end
        else
        begin
            sub_a = {3'b000, rem_reg[31:0], acc_reg[63]};
            sub_b = {4'b0000, dvs_reg};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[36];
        last_step = sqrt_reg ? (cnt_reg == 7'd31) : (cnt_reg == 7'd63);
    end

    // sequencing of the iterations
    always_comb
    begin
        busy_next = busy_reg;
        sqrt_next = sqrt_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            sqrt_next = req.is_sqrt;
            cnt_next  = 7'd0;
            acc_next  = operand;
            rem_next  = 36'd0;
            root_next = 32'd0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                rem_next  = ge ? diff[35:0] : sub_a;
                root_next = {root_reg[30:0], ge};
                acc_next  = {acc_reg[61:0], 2'b00};
            end
            else
            begin
                rem_next = {4'b0000, (ge ? diff[31:0] : sub_a[31:0])};
                acc_next = {acc_reg[62:0], ge};
            end
            cnt_next = cnt_reg + 7'd1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sqrt_reg <= sqrt_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvs_reg  <= dvs_next;
    end

    assign done   = done_reg;
    assign result = sqrt_reg ? {32'd0, root_reg} : acc_reg;

endmodule

// ===== design/trapezoidal_profile_generator.sv =====
// trapezoidal velocity profile generator, at most one sample per input transaction
// tick: two divides from accept to result; a third divide in the cruise phase
// restart: plan of a nonzero move (trapezoid or triangle), then the tick sequence if samples remain
// s_tready rises together with the registered result; output stalls hold the sample in the emit state
// reset (asynchronous, active low) returns configuration and control registers to defaults and goes idle
module trapezoidal_profile_generator
#(
    parameter int POSITION_FRAC_BITS = 16,
    parameter int OUTPUT_FRAC_BITS   = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] restart, [7:1] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [31:0] fraction, [63:32] sample_index
    output logic        m_tlast,      // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "trapezoidal_profile_generator_defines.svh"

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_PV2   = 17'h00002,
        S_PV2D  = 17'h00004,
        S_PRAMP = 17'h00008,
        S_PCRZ  = 17'h00010,
        S_PQ    = 17'h00020,
        S_PSQ   = 17'h00040,
        S_PNUM  = 17'h00080,
        S_PCHK  = 17'h00100,
        S_TTM   = 17'h00200,
        S_TV2M  = 17'h00400,
        S_TV2D  = 17'h00800,
        S_TM1   = 17'h01000,
        S_TM2   = 17'h02000,
        S_TS    = 17'h04000,
        S_TFRAC = 17'h08000,
        S_EMIT  = 17'h10000
    } state_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } phase_t;

    localparam logic signed [32:0] FRAC_ONE = 33'(64'd1 << OUTPUT_FRAC_BITS);

    // configuration registers
    logic [31:0] start_pos_reg, end_pos_reg, accel_reg, speed_reg;
    logic [16:0] rate_reg;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic        wait_reg, wait_next;
    logic        running_reg, running_next;
    logic [31:0] index_reg, index_next;
    logic [31:0] acc_end_reg, acc_end_next;
    logic [31:0] cruise_end_reg, cruise_end_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] samples_reg, samples_next;
    logic [31:0] v2a_reg, v2a_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] mfac_reg, mfac_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] frac_reg, frac_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_frac_reg, out_frac_next;
    logic [31:0] out_index_reg, out_index_next;
    logic        out_last_reg, out_last_next;

    // derived operands
    logic [32:0] diff33, abs33;
    logic [31:0] move_len;
    logic        neg_move;
    logic [31:0] acc_e, spd_e;
    logic [16:0] rate_e;
    logic [31:0] prod_sat;

    // shared unit interface
    tpg_pkg::dsq_req_t dsq_req;
    logic [63:0] dsq_operand;
    logic [31:0] dsq_divisor;
    logic        dsq_done;
    logic [63:0] dsq_result;
    logic [31:0] dsq_sat;
    logic        div_state;

    // multiplier
    logic [31:0] mul_a, mul_b;
    logic        mul_state;

    // phase working values
    logic [31:0] tm_w, dt_w, rem_w, s_w, peak_w, cruise_w, q_w;
    logic        in_accept;

    // sign-extended output fraction for the range check
    logic signed [32:0] frac_ext;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // move length and direction, zero-guarded parameters and saturated results
    always_comb
    begin
        diff33   = {end_pos_reg[31], end_pos_reg} - {start_pos_reg[31], start_pos_reg};
        abs33    = diff33[32] ? (33'd0 - diff33) : diff33;
        move_len = abs33[31:0];
        neg_move = diff33[32];
        acc_e    = (accel_reg == 32'd0) ? 32'd1 : accel_reg;
        spd_e    = (speed_reg == 32'd0) ? 32'd1 : speed_reg;
        rate_e   = (rate_reg == 17'd0) ? 17'd1 : rate_reg;
        prod_sat = tpg_pkg::sat32(prod_reg >> POSITION_FRAC_BITS);
        dsq_sat  = tpg_pkg::sat32(dsq_result);
    end

    // operand selection for the shared divide / root unit
    always_comb
    begin
        dsq_operand     = 64'd0;
        dsq_divisor     = acc_e;
        dsq_req.is_sqrt = 1'b0;
        div_state       = 1'b1;
        case (state_reg)
            S_PV2D, S_TV2D:
            begin
                dsq_operand = prod_reg;
            end
            S_PRAMP:
            begin
                dsq_operand = {32'd0, spd_e} << POSITION_FRAC_BITS;
            end
            S_PCRZ:
            begin
                dsq_operand = {32'd0, move_len - v2a_reg} << POSITION_FRAC_BITS;
                dsq_divisor = spd_e;
            end
            S_PQ:
            begin
                dsq_operand = {32'd0, move_len} << POSITION_FRAC_BITS;
            end
            S_PSQ:
            begin
                dsq_operand     = dsq_result << POSITION_FRAC_BITS;
                dsq_req.is_sqrt = 1'b1;
            end
            S_TTM:
            begin
                dsq_operand = {32'd0, index_reg} << POSITION_FRAC_BITS;
                dsq_divisor = {15'd0, rate_e};
            end
            S_TFRAC:
            begin
                dsq_operand = {32'd0, s_reg} << OUTPUT_FRAC_BITS;
                dsq_divisor = move_len;
            end
            default:
            begin
                div_state = 1'b0;
            end
        endcase
        dsq_req.start = div_state && !wait_reg;
    end

    tpg_divsqrt u_divsqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (dsq_req),
        .operand (dsq_operand),
        .divisor (dsq_divisor),
        .done    (dsq_done),
        .result  (dsq_result)
    );

    // multiplier operand selection
    always_comb
    begin
        mul_a     = spd_e;
        mul_b     = spd_e;
        mul_state = 1'b1;
        case (state_reg)
            S_PV2, S_TV2M:
            begin
                mul_a = spd_e;
                mul_b = spd_e;
            end
            S_PNUM:
            begin
                mul_a = total_reg;
                mul_b = {15'd0, rate_e};
            end
            S_TM1:
            begin
                mul_a = (phase_reg == PH_CRUISE) ? spd_e : acc_e;
                mul_b = mfac_reg;
            end
            S_TM2:
            begin
                mul_a = prod_sat;
                mul_b = mfac_reg;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
        prod_next = mul_state ? (64'(mul_a) * 64'(mul_b)) : prod_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        wait_next       = wait_reg;
        running_next    = running_reg;
        index_next      = index_reg;
        acc_end_next    = acc_end_reg;
        cruise_end_next = cruise_end_reg;
        total_next      = total_reg;
        samples_next    = samples_reg;
        v2a_next        = v2a_reg;
        mfac_next       = mfac_reg;
        s_next          = s_reg;
        frac_next       = frac_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_frac_next   = out_frac_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;

        tm_w     = dsq_sat;
        dt_w     = (total_reg > tm_w) ? (total_reg - tm_w) : 32'd0;
        q_w      = dsq_sat;
        peak_w   = q_w;
        cruise_w = tpg_pkg::addsat32(acc_end_reg, q_w);
        rem_w    = prod_sat >> 1;
        s_w      = 32'd0;

        if (dsq_req.start)
        begin
            wait_next = 1'b1;
        end
        if (dsq_done)
        begin
            wait_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tdata[0])
                    begin
                        running_next = 1'b0;
                        index_next   = 32'd0;
                        if (move_len == 32'd0)
                        begin
                            acc_end_next    = 32'd0;
                            cruise_end_next = 32'd0;
                            total_next      = 32'd0;
                            samples_next    = 32'd0;
                        end
                        else
                        begin
                            state_next = S_PV2;
                        end
                    end
                    else if (running_reg)
                    begin
                        state_next = S_TTM;
                    end
                end
            end
            // plan: v*v / a
            S_PV2:
            begin
                state_next = S_PV2D;
            end
            S_PV2D:
            begin
                if (dsq_done)
                begin
                    v2a_next   = dsq_sat;
                    state_next = (move_len > dsq_sat) ? S_PRAMP : S_PQ;
                end
            end
            // plan: trapezoid ramp time and cruise end
            S_PRAMP:
            begin
                if (dsq_done)
                begin
                    acc_end_next = dsq_sat;
                    state_next   = S_PCRZ;
                end
            end
            S_PCRZ:
            begin
                if (dsq_done)
                begin
                    cruise_end_next = cruise_w;
                    total_next      = tpg_pkg::addsat32(cruise_w, acc_end_reg);
                    state_next      = S_PNUM;
                end
            end
            // plan: triangle peak time
            S_PQ:
            begin
                if (dsq_done)
                begin
                    if ((dsq_result >> (64 - POSITION_FRAC_BITS)) != 64'd0)
                    begin
                        acc_end_next    = tpg_pkg::SAT32;
                        cruise_end_next = tpg_pkg::SAT32;
                        total_next      = tpg_pkg::SAT32;
                        state_next      = S_PNUM;
                    end
                    else
                    begin
                        state_next = S_PSQ;
                    end
                end
            end
            S_PSQ:
            begin
                if (dsq_done)
                begin
                    peak_w          = dsq_result[31:0];
                    acc_end_next    = peak_w;
                    cruise_end_next = peak_w;
                    total_next      = tpg_pkg::addsat32(peak_w, peak_w);
                    state_next      = S_PNUM;
                end
            end
            // plan: sample count
            S_PNUM:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                samples_next = prod_sat;
                if (prod_sat == 32'd0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    running_next = 1'b1;
                    state_next   = S_TTM;
                end
            end
            // tick: sample time and phase
            S_TTM:
            begin
                if (dsq_done)
                begin
                    if (move_len == 32'd0)
                    begin
                        frac_next  = 32'd0;
                        state_next = S_EMIT;
                    end
                    else if (tm_w < acc_end_reg)
                    begin
                        phase_next = PH_ACCEL;
                        mfac_next  = tm_w;
                        state_next = S_TM1;
                    end
                    else if (tm_w < cruise_end_reg)
                    begin
                        phase_next = PH_CRUISE;
                        mfac_next  = tm_w - acc_end_reg;
                        state_next = S_TV2M;
                    end
                    else
                    begin
                        phase_next = PH_DECEL;
                        mfac_next  = dt_w;
                        state_next = S_TM1;
                    end
                end
            end
            S_TV2M:
            begin
                state_next = S_TV2D;
            end
            S_TV2D:
            begin
                if (dsq_done)
                begin
                    v2a_next   = dsq_sat;
                    state_next = S_TM1;
                end
            end
            S_TM1:
            begin
                state_next = (phase_reg == PH_CRUISE) ? S_TS : S_TM2;
            end
            S_TM2:
            begin
                state_next = S_TS;
            end
            // travelled distance, clamped to the move length
            S_TS:
            begin
                case (phase_reg)
                    PH_ACCEL:  s_w = rem_w;
                    PH_CRUISE: s_w = tpg_pkg::addsat32(v2a_reg >> 1, prod_sat);
                    PH_DECEL:  s_w = move_len - ((rem_w < move_len) ? rem_w : move_len);
                    default:   s_w = 32'd0;
                endcase
                s_next     = (s_w > move_len) ? move_len : s_w;
                state_next = S_TFRAC;
            end
            S_TFRAC:
            begin
                if (dsq_done)
                begin
                    frac_next  = neg_move ? (32'd0 - dsq_result[31:0]) : dsq_result[31:0];
                    state_next = S_EMIT;
                end
            end
            // hand the sample to the output register
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_frac_next  = frac_reg;
                    out_index_next = index_reg;
                    out_last_next  = (index_reg == samples_reg - 32'd1);
                    if ({1'b0, index_reg} + 33'd1 >= {1'b0, samples_reg})
                    begin
                        running_next = 1'b0;
                    end
                    else
                    begin
                        index_next = index_reg + 32'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= tpg_pkg::START_RESET;
            end_pos_reg   <= tpg_pkg::END_RESET;
            accel_reg     <= tpg_pkg::ACC_RESET;
            speed_reg     <= tpg_pkg::SPD_RESET;
            rate_reg      <= tpg_pkg::RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tpg_pkg::REG_START: start_pos_reg <= cfg_data;
                tpg_pkg::REG_END:   end_pos_reg   <= cfg_data;
                tpg_pkg::REG_ACC:   accel_reg     <= cfg_data;
                tpg_pkg::REG_SPD:   speed_reg     <= cfg_data;
                tpg_pkg::REG_RATE:  rate_reg      <= cfg_data[16:0];
                default:            ;
            endcase
        end
    end

    // control and profile state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_ACCEL;
            wait_reg       <= 1'b0;
            running_reg    <= 1'b0;
            index_reg      <= 32'd0;
            acc_end_reg    <= 32'd0;
            cruise_end_reg <= 32'd0;
            total_reg      <= 32'd0;
            samples_reg    <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            wait_reg       <= wait_next;
            running_reg    <= running_next;
            index_reg      <= index_next;
            acc_end_reg    <= acc_end_next;
            cruise_end_reg <= cruise_end_next;
            total_reg      <= total_next;
            samples_reg    <= samples_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        v2a_reg       <= v2a_next;
        prod_reg      <= prod_next;
        mfac_reg      <= mfac_next;
        s_reg         <= s_next;
        frac_reg      <= frac_next;
        out_frac_reg  <= out_frac_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_frac_reg};
    assign m_tlast  = out_last_reg;

    assign frac_ext = {out_frac_reg[31], out_frac_reg};

    // checks
    `TPG_ASSERT_IMP(a_index_in_range, running_reg, index_reg < samples_reg, "index past end")
    `TPG_ASSERT_IMP(a_frac_bounded, out_valid_reg, (frac_ext <= FRAC_ONE) && (frac_ext >= -FRAC_ONE), "fraction out of range")
    `TPG_ASSERT_IMP(a_done_expected, !wait_reg, !dsq_done, "unit done without request")

endmodule
